@@ src/mxq_pkg.sv @@
// ----------------------------------------------------------------------------
// mxq_pkg: shared types and codes for the maximum-xor query store
// Status codes, item kind codes and the control group that travels with
// each token along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mxq_pkg;

    // Width of the payload ports
    localparam int FIELD_BITS = 30;

    // Item kind, as carried on the mode input
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Result status
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Control group of a token moving down the chain
    typedef struct packed {
        logic    valid;   // token slot holds an item
        logic    query;   // query item, otherwise insert
        t_status status;  // insert outcome decided at entry
        logic    found;   // a qualifying entry has been seen
    } t_ctl;

endpackage

`default_nettype wire

@@ src/mxq_cell.sv @@
// ----------------------------------------------------------------------------
// mxq_cell: one storage cell of the query chain
// Holds one stored value. Captures the insert token addressed to its slot,
// folds its value into each passing query that it qualifies for and hands the token on.
// ----------------------------------------------------------------------------
`default_nettype none

module mxq_cell #(
    parameter int VALUE_BITS = 30,
    parameter int CNT_W      = 11,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mxq_pkg::t_ctl         i_ctl,
    input  wire logic [CNT_W-1:0]      i_idx,
    input  wire logic [VALUE_BITS-1:0] i_x,
    input  wire logic [VALUE_BITS-1:0] i_lim,
    input  wire logic [VALUE_BITS-1:0] i_best,
    output mxq_pkg::t_ctl              o_ctl,
    output logic [CNT_W-1:0]           o_idx,
    output logic [VALUE_BITS-1:0]      o_x,
    output logic [VALUE_BITS-1:0]      o_lim,
    output logic [VALUE_BITS-1:0]      o_best
);
    import mxq_pkg::*;

    localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

    logic [VALUE_BITS-1:0] r_value;
    t_ctl                  r_ctl;
    logic [CNT_W-1:0]      r_idx;
    logic [VALUE_BITS-1:0] r_x;
    logic [VALUE_BITS-1:0] r_lim;
    logic [VALUE_BITS-1:0] r_best;

    logic                  write_hit;
    logic                  qualify;
    logic                  take;
    logic [VALUE_BITS-1:0] cand;
    t_ctl                  n_ctl;
    logic [VALUE_BITS-1:0] n_best;

    // Insert lands here when its slot number matches and it was not dropped
    assign write_hit = i_ctl.valid && !i_ctl.query && (i_ctl.status == ST_OK)
                       && (i_idx == SLOT);

    // Query sees this slot only if it was filled before the query entered
    assign qualify = i_ctl.valid && i_ctl.query && (SLOT < i_idx)
                     && (r_value <= i_lim);
    assign cand    = r_value ^ i_x;
    assign take    = qualify && (!i_ctl.found || (cand > i_best));

    always_comb begin
        n_ctl       = i_ctl;
        n_ctl.found = i_ctl.found | qualify;
        n_best      = take ? cand : i_best;
    end

    // Hold stored value
    always_ff @(posedge i_clk) begin
        if (write_hit) begin
            r_value <= i_x;
        end
    end

    // Advance token control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // Advance token payload
    always_ff @(posedge i_clk) begin
        r_idx  <= i_idx;
        r_x    <= i_x;
        r_lim  <= i_lim;
        r_best <= n_best;
    end

    assign o_ctl  = r_ctl;
    assign o_idx  = r_idx;
    assign o_x    = r_x;
    assign o_lim  = r_lim;
    assign o_best = r_best;

endmodule

`default_nettype wire

@@ src/bounded_max_xor_query_store.sv @@
// ----------------------------------------------------------------------------
// bounded_max_xor_query_store: store of values with bounded max-xor queries
// Values sit in a chain of ENTRIES cells; every item travels the chain as a
// token, one cell per cycle, and leaves with its result at the far end.
// ----------------------------------------------------------------------------
// An item is transferred whenever start is high; busy never rises, so one
// item can be taken every cycle. Each item's result appears on o_done,
// o_status and o_best_xor in transfer order, after the register of every
// cell of the chain and then the output register. The receiver cannot
// stall and must take every result in the
// cycle it is shown. An insert into a full store answers status full; a
// query with no stored value at or below its limit answers status none.
// Both report best_xor as zero, as does every insert.
`default_nettype none

module bounded_max_xor_query_store #(
    parameter int VALUE_BITS = 30,
    parameter int ENTRIES    = 1024
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_mode,
    input  wire logic [mxq_pkg::FIELD_BITS-1:0] i_value,
    input  wire logic [mxq_pkg::FIELD_BITS-1:0] i_limit,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [mxq_pkg::FIELD_BITS-1:0]  o_best_xor
);
    import mxq_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CW    = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    // Token links between cells
    t_ctl                  link_ctl  [ENTRIES+1];
    logic [CNT_W-1:0]      link_idx  [ENTRIES+1];
    logic [VALUE_BITS-1:0] link_x    [ENTRIES+1];
    logic [VALUE_BITS-1:0] link_lim  [ENTRIES+1];
    logic [VALUE_BITS-1:0] link_best [ENTRIES+1];

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  full;
    logic                  ins_ok;

    logic                  r_done;
    t_status               r_status;
    logic [FIELD_BITS-1:0] r_best;
    t_ctl                  tail;

    assign busy   = 1'b0;
    assign full   = (r_count == FULL_COUNT);
    assign ins_ok = start && (i_mode == MODE_INSERT) && !full;

    // Build the entering token; inserts carry their slot, queries the fill count
    always_comb begin
        link_ctl[0].valid  = start;
        link_ctl[0].query  = (i_mode == MODE_QUERY);
        link_ctl[0].status = ((i_mode == MODE_INSERT) && full) ? ST_FULL : ST_OK;
        link_ctl[0].found  = 1'b0;
        link_idx[0]        = r_count;
        link_x[0]          = VALUE_BITS'(i_value[CW-1:0]);
        link_lim[0]        = VALUE_BITS'(i_limit[CW-1:0]);
        link_best[0]       = '0;
        n_count            = ins_ok ? (r_count + CNT_W'(1)) : r_count;
    end

    // Hold fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Chain of storage cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        mxq_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (link_ctl[g]),
            .i_idx   (link_idx[g]),
            .i_x     (link_x[g]),
            .i_lim   (link_lim[g]),
            .i_best  (link_best[g]),
            .o_ctl   (link_ctl[g+1]),
            .o_idx   (link_idx[g+1]),
            .o_x     (link_x[g+1]),
            .o_lim   (link_lim[g+1]),
            .o_best  (link_best[g+1])
        );
    end

    assign tail = link_ctl[ENTRIES];

    // Register result at the end of the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.query && !tail.found) begin
            r_status <= ST_NONE;
        end else begin
            r_status <= tail.status;
        end
        r_best <= tail.found ? FIELD_BITS'(link_best[ENTRIES][CW-1:0]) : '0;
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_best_xor = r_best;

    // Unused link outputs at the tail
    logic unused_tail;
    assign unused_tail = ^{link_idx[ENTRIES], link_x[ENTRIES], link_lim[ENTRIES]};

endmodule

`default_nettype wire
